/* hdl/cbrs_pkg.sv */
// ----------------------------------------------------------------------------
// cbrs_pkg
// Shared types, codes and constants for the CAN bus-off recovery supervisor.
// ----------------------------------------------------------------------------
package cbrs_pkg;

    localparam int TIME_BITS = 48;
    localparam int MS_BITS   = 16;
    localparam int US_BITS   = 26;   // 65535 ms * 1000 fits in 26 bits
    localparam int LVL_BITS  = 3;
    localparam int SPC_BITS  = 24;
    localparam int CNT_BITS  = 8;
    localparam int CFG_DATA_BITS = 24;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [MS_BITS-1:0]   ms_t;
    typedef logic [US_BITS-1:0]   us_t;
    typedef logic [LVL_BITS-1:0]  level_t;
    typedef logic [SPC_BITS-1:0]  span_t;
    typedef logic [CNT_BITS-1:0]  count_t;

    localparam ms_t HARD_BLOCK_MS = ms_t'(200);

    typedef enum logic
    {
        OP_POLL = 1'b0,
        OP_HARD = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        BUS_STOPPED    = 2'd0,
        BUS_RUNNING    = 2'd1,
        BUS_OFF        = 2'd2,
        BUS_RECOVERING = 2'd3
    } bus_state_t;

    typedef enum logic [2:0]
    {
        CFG_BASE_BACKOFF    = 3'd0,
        CFG_MAX_BACKOFF     = 3'd1,
        CFG_MAX_LEVEL       = 3'd2,
        CFG_RECOVERY_TMO    = 3'd3,
        CFG_RESET_SPACING   = 3'd4,
        CFG_HARD_QUEUE_THR  = 3'd5,
        CFG_HARD_ERROR_THR  = 3'd6,
        CFG_RESTART_BACKOFF = 3'd7
    } cfg_index_t;

    typedef struct packed
    {
        ms_t    base_backoff_ms;
        ms_t    max_backoff_ms;
        level_t max_level;
        span_t  recovery_timeout_us;
        span_t  reset_spacing_us;
        count_t hard_queue_threshold;
        count_t hard_error_threshold;
        ms_t    restart_backoff_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        base_backoff_ms:      ms_t'(120),
        max_backoff_ms:       ms_t'(2000),
        max_level:            level_t'(6),
        recovery_timeout_us:  span_t'(600000),
        reset_spacing_us:     span_t'(1000000),
        hard_queue_threshold: count_t'(16),
        hard_error_threshold: count_t'(96),
        restart_backoff_ms:   ms_t'(80)
    };

    typedef struct packed
    {
        opcode_t    opcode;
        time_t      now_us;
        bus_state_t bus_state;
        count_t     tx_queue_depth;
        count_t     tx_error_count;
        logic       command_accepted;
    } item_t;

    typedef struct packed
    {
        logic   recovery_active;
        level_t backoff_level;
        time_t  next_attempt_time;
        time_t  recovery_start_time;
        time_t  last_forced_restart_time;
        time_t  last_hard_restart_time;
        time_t  block_deadline;
    } state_t;

    localparam state_t STATE_RESET = '{
        recovery_active:          1'b0,
        backoff_level:            '0,
        next_attempt_time:        '0,
        recovery_start_time:      '0,
        last_forced_restart_time: '0,
        last_hard_restart_time:   '0,
        block_deadline:           '0
    };

    typedef struct packed
    {
        logic clear_queue;
        logic initiate_recovery;
        logic stop_controller;
        logic start_controller;
    } cmd_t;

endpackage

/* hdl/cbrs_step.sv */
// ----------------------------------------------------------------------------
// cbrs_step
// Next-state and command logic for one status event.
// ----------------------------------------------------------------------------
module cbrs_step
    import cbrs_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t state,
    input  item_t  item,
    output state_t state_next,
    output cmd_t   cmd
);

    localparam int SHIFT_BITS = MS_BITS + (1 << LVL_BITS) - 1;

    logic                  is_poll;
    logic                  bus_off;
    logic                  recov_gt_tmo;
    logic                  forced_gt_spc;
    logic                  hard_ge_spc;
    logic                  attempt_due;
    logic                  do_init;
    logic                  do_begin;
    logic                  do_forced;
    logic                  do_restart;
    logic                  do_running;
    logic                  do_hard;
    level_t                level_inc;
    level_t                level_sel;
    logic [SHIFT_BITS-1:0] shifted;
    ms_t                   level_ms;
    ms_t                   push_ms;
    us_t                   push_us;
    logic [TIME_BITS:0]    sum;
    time_t                 push_end;
    time_t                 diff_recov;
    time_t                 diff_forced;
    time_t                 diff_hard;

    assign is_poll = (item.opcode == OP_POLL);
    assign bus_off = (item.bus_state == BUS_OFF);

    // elapsed times; a time earlier than the stamp never satisfies a spacing
    assign diff_recov  = item.now_us - state.recovery_start_time;
    assign diff_forced = item.now_us - state.last_forced_restart_time;
    assign diff_hard   = item.now_us - state.last_hard_restart_time;

    assign recov_gt_tmo  = (item.now_us > state.recovery_start_time)
                         && (diff_recov > time_t'(cfg.recovery_timeout_us));
    assign forced_gt_spc = (item.now_us > state.last_forced_restart_time)
                         && (diff_forced > time_t'(cfg.reset_spacing_us));
    assign hard_ge_spc   = (item.now_us >= state.last_hard_restart_time)
                         && (diff_hard >= time_t'(cfg.reset_spacing_us));
    assign attempt_due   = (item.now_us >= state.next_attempt_time);

    assign do_init    = is_poll && bus_off && !state.recovery_active && attempt_due;
    assign do_begin   = do_init && item.command_accepted;
    assign do_forced  = is_poll && bus_off && state.recovery_active
                      && recov_gt_tmo && forced_gt_spc && attempt_due;
    assign do_restart = is_poll && (item.bus_state == BUS_STOPPED);
    assign do_running = is_poll && (item.bus_state == BUS_RUNNING);
    assign do_hard    = !is_poll && hard_ge_spc
                      && (item.tx_queue_depth >= cfg.hard_queue_threshold)
                      && (item.tx_error_count >= cfg.hard_error_threshold);

    assign level_inc = (state.backoff_level < cfg.max_level)
                     ? state.backoff_level + level_t'(1) : cfg.max_level;
    assign level_sel = do_forced ? level_inc : state.backoff_level;

    // doubling stops once the cap is reached, so one shift and a clamp match it
    assign shifted  = SHIFT_BITS'(cfg.base_backoff_ms) << level_sel;
    assign level_ms = (shifted < SHIFT_BITS'(cfg.max_backoff_ms))
                    ? shifted[MS_BITS-1:0] : cfg.max_backoff_ms;

    always_comb
    begin
        priority if (do_begin || do_forced)
            push_ms = level_ms;
        else if (do_restart && item.command_accepted)
            push_ms = cfg.restart_backoff_ms;
        else if (do_hard)
            push_ms = HARD_BLOCK_MS;
        else
            push_ms = '0;
    end

    // ms * 1000 = ms * (1024 - 16 - 8)
    assign push_us  = (us_t'(push_ms) << 10) - (us_t'(push_ms) << 4) - (us_t'(push_ms) << 3);
    assign sum      = {1'b0, item.now_us} + (TIME_BITS+1)'(push_us);
    assign push_end = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

    always_comb
    begin
        state_next = state;
        cmd        = '0;

        cmd.clear_queue = is_poll && (item.tx_queue_depth != '0);

        if (do_init)
        begin
            cmd.initiate_recovery = 1'b1;
        end
        if (do_begin)
        begin
            state_next.recovery_active     = 1'b1;
            state_next.recovery_start_time = item.now_us;
            state_next.next_attempt_time   = push_end;
        end
        if (do_forced)
        begin
            state_next.last_forced_restart_time = item.now_us;
            state_next.recovery_active          = 1'b0;
            state_next.backoff_level            = level_inc;
            state_next.next_attempt_time        = push_end;
            cmd.clear_queue      = 1'b1;
            cmd.stop_controller  = 1'b1;
            cmd.start_controller = 1'b1;
        end
        if (do_restart)
        begin
            cmd.start_controller = 1'b1;
        end
        if (do_running)
        begin
            state_next.recovery_active     = 1'b0;
            state_next.recovery_start_time = '0;
            state_next.backoff_level       = '0;
            state_next.next_attempt_time   = '0;
        end
        if (do_hard)
        begin
            state_next.last_hard_restart_time = item.now_us;
            state_next.recovery_active        = 1'b0;
            cmd.clear_queue      = 1'b1;
            cmd.stop_controller  = 1'b1;
            cmd.start_controller = 1'b1;
        end

        // deadline only moves later; a zero backoff leaves it alone
        if ((push_ms != '0) && (push_end > state.block_deadline))
        begin
            state_next.block_deadline = push_end;
        end
    end

endmodule

/* hdl/can_busoff_recovery_supervisor.sv */
// ----------------------------------------------------------------------------
// can_busoff_recovery_supervisor
// Bus-off recovery supervisor with exponential backoff for a CAN controller.
// ----------------------------------------------------------------------------
// An event passes the input register, then the result register; the state
// update between the two registers is combinational.
// Throughput: one status event per cycle while the result channel keeps up.
// Reset (rst_n low, async): pipeline empty, recovery state cleared, all
// configuration registers back to their defaults. Config port never stalls.
// ----------------------------------------------------------------------------
module can_busoff_recovery_supervisor
    import cbrs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    // status event channel
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     opcode,
    input  logic [TIME_BITS-1:0]     now_us,
    input  logic [1:0]               bus_state,
    input  logic [CNT_BITS-1:0]      tx_queue_depth,
    input  logic [CNT_BITS-1:0]      tx_error_count,
    input  logic                     command_accepted,

    // result channel
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic                     clear_queue,
    output logic                     initiate_recovery,
    output logic                     stop_controller,
    output logic                     start_controller,
    output logic [TIME_BITS-1:0]     tx_block_until_us,
    output logic [LVL_BITS-1:0]      escalation_level,
    output logic                     recovering,

    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [2:0]               cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    cfg_t   cfg_reg;
    state_t state_reg;
    state_t state_next;
    cmd_t   cmd;

    logic   in_valid_reg;
    item_t  item_reg;
    logic   out_valid_reg;
    logic   res_load;
    logic   fire;
    logic   in_take;

    cmd_t   res_cmd_reg;
    time_t  res_deadline_reg;
    level_t res_level_reg;
    logic   res_recov_reg;

    // The result register loads when empty or when its transfer completes;
    // the input register moves into it in the same cycle, so a new event can
    // be taken every cycle while downstream keeps up.
    assign res_load = !out_valid_reg || !out_stall;
    assign fire     = in_valid_reg && res_load;
    assign in_stall = in_valid_reg && !res_load;
    assign in_take  = in_valid && !in_stall;

    // configuration: always ready; the user must write it only while the block is idle (not enforced)
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_BASE_BACKOFF:    cfg_reg.base_backoff_ms      <= cfg_data[MS_BITS-1:0];
                CFG_MAX_BACKOFF:     cfg_reg.max_backoff_ms       <= cfg_data[MS_BITS-1:0];
                CFG_MAX_LEVEL:       cfg_reg.max_level            <= cfg_data[LVL_BITS-1:0];
                CFG_RECOVERY_TMO:    cfg_reg.recovery_timeout_us  <= cfg_data[SPC_BITS-1:0];
                CFG_RESET_SPACING:   cfg_reg.reset_spacing_us     <= cfg_data[SPC_BITS-1:0];
                CFG_HARD_QUEUE_THR:  cfg_reg.hard_queue_threshold <= cfg_data[CNT_BITS-1:0];
                CFG_HARD_ERROR_THR:  cfg_reg.hard_error_threshold <= cfg_data[CNT_BITS-1:0];
                CFG_RESTART_BACKOFF: cfg_reg.restart_backoff_ms   <= cfg_data[MS_BITS-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.opcode           <= opcode_t'(opcode);
            item_reg.now_us           <= now_us;
            item_reg.bus_state        <= bus_state_t'(bus_state);
            item_reg.tx_queue_depth   <= tx_queue_depth;
            item_reg.tx_error_count   <= tx_error_count;
            item_reg.command_accepted <= command_accepted;
        end
    end

    cbrs_step u_step
    (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .cmd        (cmd)
    );

    // supervisor state commits with the event leaving the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_cmd_reg      <= cmd;
            res_deadline_reg <= state_next.block_deadline;
            res_level_reg    <= state_next.backoff_level;
            res_recov_reg    <= state_next.recovery_active;
        end
    end

    assign out_valid         = out_valid_reg;
    assign clear_queue       = res_cmd_reg.clear_queue;
    assign initiate_recovery = res_cmd_reg.initiate_recovery;
    assign stop_controller   = res_cmd_reg.stop_controller;
    assign start_controller  = res_cmd_reg.start_controller;
    assign tx_block_until_us = res_deadline_reg;
    assign escalation_level  = res_level_reg;
    assign recovering        = res_recov_reg;

endmodule

/* sim/cbrs_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbrs_check_pkg
// Result tracker for the bus-off recovery supervisor test: mirrors the
// configuration and recovery state, predicts one action per status event and
// checks the actions the block returns against those predictions in order.
// ----------------------------------------------------------------------------
package cbrs_check_pkg;
    import cbrs_pkg::*;

    // One result transfer as seen on the output channel
    typedef struct packed
    {
        cmd_t   cmd;
        time_t  block_until;
        level_t level;
        logic   recovering;
    } action_t;

    localparam time_t TIME_LIMIT = '1;

    class supervisor_ledger;
        cfg_t    regs;
        state_t  st;
        action_t pending_actions[$];
        int      mismatches;

        function new();
            regs = CFG_RESET;
            st = STATE_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_BASE_BACKOFF:    regs.base_backoff_ms = val[15:0];
                CFG_MAX_BACKOFF:     regs.max_backoff_ms = val[15:0];
                CFG_MAX_LEVEL:       regs.max_level = val[2:0];
                CFG_RECOVERY_TMO:    regs.recovery_timeout_us = val;
                CFG_RESET_SPACING:   regs.reset_spacing_us = val;
                CFG_HARD_QUEUE_THR:  regs.hard_queue_threshold = val[7:0];
                CFG_HARD_ERROR_THR:  regs.hard_error_threshold = val[7:0];
                CFG_RESTART_BACKOFF: regs.restart_backoff_ms = val[15:0];
                default: ;
            endcase
        endfunction

        // Base doubled once per level until it reaches the cap, then capped
        function logic [31:0] level_delay_ms(level_t lvl);
            logic [31:0] ms;
            int          n;
            ms = 32'(regs.base_backoff_ms);
            n = int'(lvl);
            while (n > 0 && ms < 32'(regs.max_backoff_ms)) begin
                ms = ms << 1;
                n--;
            end
            return (ms > 32'(regs.max_backoff_ms)) ? 32'(regs.max_backoff_ms) : ms;
        endfunction

        // now + ms, saturating at the top of the time range
        function time_t time_after(time_t now, logic [31:0] ms);
            logic [63:0] add;
            add = 64'(ms) * 64'd1000;
            if (64'(now) > 64'(TIME_LIMIT) - add)
                return TIME_LIMIT;
            return now + time_t'(add);
        endfunction

        // strictly later than then by more than lim; an earlier now never qualifies
        function logic elapsed_over(time_t now, time_t then, span_t lim);
            return (now > then) && ((now - then) > 48'(lim));
        endfunction

        // deadline only moves later; a zero backoff leaves it alone
        function void push_deadline(time_t now, logic [31:0] ms);
            time_t deadline;
            if (ms == 0)
                return;
            deadline = time_after(now, ms);
            if (deadline > st.block_deadline)
                st.block_deadline = deadline;
        endfunction

        function void note_event(item_t ev);
            action_t     a;
            logic [31:0] ms;
            time_t       now;
            a = '0;
            now = ev.now_us;
            if (ev.opcode == OP_POLL) begin
                a.cmd.clear_queue = (ev.tx_queue_depth != 0);
                if (ev.bus_state == BUS_OFF && !st.recovery_active) begin
                    if (now >= st.next_attempt_time) begin
                        a.cmd.initiate_recovery = 1'b1;
                        if (ev.command_accepted) begin
                            st.recovery_active = 1'b1;
                            st.recovery_start_time = now;
                            ms = level_delay_ms(st.backoff_level);
                            st.next_attempt_time = time_after(now, ms);
                            push_deadline(now, ms);
                        end
                    end
                end
                else if (ev.bus_state == BUS_OFF) begin
                    // recovery stuck: forced restart and one level up
                    if (elapsed_over(now, st.recovery_start_time, regs.recovery_timeout_us) &&
                        elapsed_over(now, st.last_forced_restart_time, regs.reset_spacing_us) &&
                        now >= st.next_attempt_time) begin
                        st.last_forced_restart_time = now;
                        a.cmd = '{1'b1, 1'b0, 1'b1, 1'b1};
                        st.recovery_active = 1'b0;
                        st.backoff_level = (st.backoff_level < regs.max_level) ?
                                           st.backoff_level + 3'd1 : regs.max_level;
                        ms = level_delay_ms(st.backoff_level);
                        st.next_attempt_time = time_after(now, ms);
                        push_deadline(now, ms);
                    end
                end
                else if (ev.bus_state == BUS_STOPPED) begin
                    a.cmd.start_controller = 1'b1;
                    if (ev.command_accepted)
                        push_deadline(now, 32'(regs.restart_backoff_ms));
                end
                else if (ev.bus_state == BUS_RUNNING) begin
                    st.recovery_active = 1'b0;
                    st.recovery_start_time = '0;
                    st.backoff_level = '0;
                    st.next_attempt_time = '0;
                end
            end
            else if (now >= st.last_hard_restart_time &&
                     now - st.last_hard_restart_time >= 48'(regs.reset_spacing_us) &&
                     ev.tx_queue_depth >= regs.hard_queue_threshold &&
                     ev.tx_error_count >= regs.hard_error_threshold) begin
                st.last_hard_restart_time = now;
                a.cmd = '{1'b1, 1'b0, 1'b1, 1'b1};
                st.recovery_active = 1'b0;
                push_deadline(now, 32'(HARD_BLOCK_MS));
            end
            a.block_until = st.block_deadline;
            a.level = st.backoff_level;
            a.recovering = st.recovery_active;
            pending_actions.push_back(a);
        endfunction

        function int outstanding();
            return pending_actions.size();
        endfunction

        function string describe(action_t a);
            return $sformatf("clr=%0b init=%0b stop=%0b start=%0b block=%0d level=%0d rec=%0b",
                             a.cmd.clear_queue, a.cmd.initiate_recovery,
                             a.cmd.stop_controller, a.cmd.start_controller,
                             a.block_until, a.level, a.recovering);
        endfunction

        function void check_action(action_t got);
            action_t want;
            logic    bad;
            if (pending_actions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %s", describe(got));
                return;
            end
            want = pending_actions.pop_front();
            bad = (got.cmd.clear_queue !== want.cmd.clear_queue) ||
                  (got.cmd.initiate_recovery !== want.cmd.initiate_recovery) ||
                  (got.cmd.stop_controller !== want.cmd.stop_controller) ||
                  (got.cmd.start_controller !== want.cmd.start_controller) ||
                  (got.block_until !== want.block_until) ||
                  (got.level !== want.level) ||
                  (got.recovering !== want.recovering);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch at %0t\n  expected %s\n  actual   %s",
                             $time, describe(want), describe(got));
            end
        endfunction
    endclass

endpackage

/* sim/can_busoff_recovery_supervisor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_busoff_recovery_supervisor_test
// Drives status events through the recovery supervisor under several register
// settings and idle/stall patterns; every result transfer is checked in order
// against the tracker's prediction.
// ----------------------------------------------------------------------------
module can_busoff_recovery_supervisor_test;
    import cbrs_pkg::*;
    import cbrs_check_pkg::*;

    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 230;
    localparam int TOP_EVENTS = 30;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic                     opcode;
    logic [TIME_BITS-1:0]     now_us;
    logic [1:0]               bus_state;
    logic [CNT_BITS-1:0]      tx_queue_depth;
    logic [CNT_BITS-1:0]      tx_error_count;
    logic                     command_accepted;
    logic                     out_valid;
    logic                     out_stall;
    logic                     clear_queue;
    logic                     initiate_recovery;
    logic                     stop_controller;
    logic                     start_controller;
    logic [TIME_BITS-1:0]     tx_block_until_us;
    logic [LVL_BITS-1:0]      escalation_level;
    logic                     recovering;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [2:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    supervisor_ledger ledger = new();

    // percent of cycles the sender holds off / the receiver stalls
    int         idle_pct = 0;
    int         stall_pct = 0;
    // running controller clock for generated events; bus state drifts slowly
    time_t      clock_us;
    bus_state_t drift_bus;

    can_busoff_recovery_supervisor DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .opcode            (opcode),
        .now_us            (now_us),
        .bus_state         (bus_state),
        .tx_queue_depth    (tx_queue_depth),
        .tx_error_count    (tx_error_count),
        .command_accepted  (command_accepted),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .clear_queue       (clear_queue),
        .initiate_recovery (initiate_recovery),
        .stop_controller   (stop_controller),
        .start_controller  (start_controller),
        .tx_block_until_us (tx_block_until_us),
        .escalation_level  (escalation_level),
        .recovering        (recovering),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Receiver back-pressure, redrawn every cycle
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Result monitor: values are read at the edge, before any update lands,
    // so they are exactly what the transfer carried.
    always @(posedge clk)
    begin : watch_results
        action_t seen;
        if (rst_n && out_valid && !out_stall) begin
            seen.cmd = {clear_queue, initiate_recovery, stop_controller, start_controller};
            seen.block_until = tx_block_until_us;
            seen.level = escalation_level;
            seen.recovering = recovering;
            ledger.check_action(seen);
        end
    end

    // Present one event, with random hold-off first, and keep it steady until
    // the transfer happens. Prediction is taken at the accepting edge.
    task automatic send_event(input item_t ev);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        opcode           <= ev.opcode;
        now_us           <= ev.now_us;
        bus_state        <= ev.bus_state;
        tx_queue_depth   <= ev.tx_queue_depth;
        tx_error_count   <= ev.tx_error_count;
        command_accepted <= ev.command_accepted;
        do @(posedge clk); while (in_stall);
        ledger.note_event(ev);
    endtask

    // Sender goes quiet until every predicted result has been transferred.
    // Every event yields a result, so the block is idle afterwards.
    task automatic await_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (ledger.outstanding() != 0);
    endtask

    // cfg_valid is left high here; the caller lowers it after the last write
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        ledger.set_reg(idx, val);
    endtask

    task automatic load_config(input cfg_t c);
        write_reg(CFG_BASE_BACKOFF,    24'(c.base_backoff_ms));
        write_reg(CFG_MAX_BACKOFF,     24'(c.max_backoff_ms));
        write_reg(CFG_MAX_LEVEL,       24'(c.max_level));
        write_reg(CFG_RECOVERY_TMO,    c.recovery_timeout_us);
        write_reg(CFG_RESET_SPACING,   c.reset_spacing_us);
        write_reg(CFG_HARD_QUEUE_THR,  24'(c.hard_queue_threshold));
        write_reg(CFG_HARD_ERROR_THR,  24'(c.hard_error_threshold));
        write_reg(CFG_RESTART_BACKOFF, 24'(c.restart_backoff_ms));
        cfg_valid <= 1'b0;
    endtask

    function automatic item_t status_event(opcode_t op, time_t t, bus_state_t b,
                                           int depth, int errs, bit acc);
        item_t ev;
        ev.opcode = op;
        ev.now_us = t;
        ev.bus_state = b;
        ev.tx_queue_depth = count_t'(depth);
        ev.tx_error_count = count_t'(errs);
        ev.command_accepted = acc;
        return ev;
    endfunction

    // Register settings per phase: reset values, both extremes, a slow
    // doubling ramp, a base above the cap, then random ones.
    function automatic cfg_t phase_setting(int s);
        cfg_t c;
        c.base_backoff_ms      = ms_t'($urandom_range(1, 4000));
        c.max_backoff_ms       = ms_t'($urandom_range(1, 20000));
        c.max_level            = level_t'($urandom_range(0, 7));
        c.recovery_timeout_us  = span_t'($urandom_range(0, 2000000));
        c.reset_spacing_us     = span_t'($urandom_range(0, 3000000));
        c.hard_queue_threshold = count_t'($urandom_range(0, 64));
        c.hard_error_threshold = count_t'($urandom_range(0, 200));
        c.restart_backoff_ms   = ms_t'($urandom_range(0, 500));
        case (s)
            1: c = '{ms_t'(1), ms_t'(1), level_t'(0), span_t'(0), span_t'(0),
                     count_t'(0), count_t'(0), ms_t'(0)};
            2: c = '{ms_t'(65535), ms_t'(65535), level_t'(7), span_t'(16777215),
                     span_t'(16777215), count_t'(255), count_t'(255), ms_t'(65535)};
            3: c = '{ms_t'(1), ms_t'(65535), level_t'(7), span_t'(1000), span_t'(5000),
                     count_t'(8), count_t'(40), ms_t'(1)};
            4:
            begin
                c.base_backoff_ms = ms_t'(5000);
                c.max_backoff_ms  = ms_t'(300);
                c.max_level       = level_t'(3);
            end
            default: ;
        endcase
        return c;
    endfunction

    function automatic count_t near_threshold(count_t thr);
        int v;
        v = int'(thr) + $urandom_range(0, 4) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return count_t'(v);
    endfunction

    // Mostly a forward-moving clock with bus-off runs long enough to escalate;
    // some events land right on a stored deadline, a few go back in time.
    function automatic item_t random_event();
        item_t       ev;
        logic [63:0] advance;
        logic [63:0] aim;
        logic [63:0] sum;
        int          pick;
        int          k;
        pick = $urandom_range(0, 99);
        advance = 0;
        if (pick < 40)
            advance = $urandom_range(0, 50000);
        else if (pick < 78)
            advance = $urandom_range(0, 1200000);
        else if (pick < 90)
            advance = $urandom_range(0, 2 * ledger.regs.reset_spacing_us + 2000);
        else if (pick < 95) begin
            // hit the edge of a spacing, timeout or next-attempt compare
            case ($urandom_range(0, 3))
                0: aim = ledger.st.next_attempt_time;
                1: aim = ledger.st.last_hard_restart_time + ledger.regs.reset_spacing_us;
                2: aim = ledger.st.last_forced_restart_time + ledger.regs.reset_spacing_us;
                default: aim = ledger.st.recovery_start_time + ledger.regs.recovery_timeout_us;
            endcase
            aim = aim + $urandom_range(0, 2) - 1;
            if (aim >= 64'(clock_us) && aim <= 64'(TIME_LIMIT))
                advance = aim - 64'(clock_us);
        end
        if (pick >= 95)
            ev.now_us = (clock_us > 500000) ? clock_us - time_t'($urandom_range(1, 500000))
                                            : time_t'($urandom_range(0, 1000));
        else begin
            sum = 64'(clock_us) + advance;
            clock_us = (sum > 64'(TIME_LIMIT)) ? TIME_LIMIT : time_t'(sum);
            ev.now_us = clock_us;
        end

        if ($urandom_range(0, 99) < 15) begin
            k = $urandom_range(0, 99);
            drift_bus = (k < 45) ? BUS_OFF : (k < 65) ? BUS_RUNNING :
                        (k < 85) ? BUS_STOPPED : BUS_RECOVERING;
        end
        ev.bus_state = drift_bus;
        ev.opcode = ($urandom_range(0, 99) < 20) ? OP_HARD : OP_POLL;

        k = $urandom_range(0, 99);
        ev.tx_queue_depth = (k < 30) ? count_t'(0) :
                            (k < 65) ? near_threshold(ledger.regs.hard_queue_threshold) :
                                       count_t'($urandom_range(0, 255));
        ev.tx_error_count = ($urandom_range(0, 1) == 0) ?
                            near_threshold(ledger.regs.hard_error_threshold) :
                            count_t'($urandom_range(0, 255));
        ev.command_accepted = ($urandom_range(0, 99) < 80);
        return ev;
    endfunction

    initial
    begin : main_flow
        cfg_t setting;
        int   s;
        int   i;

        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        opcode           <= OP_POLL;
        now_us           <= '0;
        bus_state        <= BUS_STOPPED;
        tx_queue_depth   <= '0;
        tx_error_count   <= '0;
        command_accepted <= 1'b0;
        cfg_valid        <= 1'b0;
        cfg_index        <= CFG_BASE_BACKOFF;
        cfg_data         <= '0;
        clock_us         = '0;
        drift_bus        = BUS_OFF;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed walk under reset register values: refused and accepted
        // initiate, stuck recovery forcing a restart, next-attempt gating,
        // hard check on both sides of each threshold and of the spacing,
        // time going backwards, stopped and running controller.
        send_event(status_event(OP_POLL, 48'd0,       BUS_RUNNING,    0,   0,   0));
        send_event(status_event(OP_POLL, 48'd1000,    BUS_OFF,        0,   0,   0));
        send_event(status_event(OP_POLL, 48'd2000,    BUS_OFF,        255, 255, 1));
        send_event(status_event(OP_POLL, 48'd100000,  BUS_OFF,        3,   7,   1));
        send_event(status_event(OP_POLL, 48'd150000,  BUS_RECOVERING, 5,   0,   1));
        send_event(status_event(OP_POLL, 48'd1000000, BUS_OFF,        0,   0,   1));
        send_event(status_event(OP_POLL, 48'd1000001, BUS_OFF,        0,   0,   1));
        send_event(status_event(OP_POLL, 48'd1100000, BUS_OFF,        1,   0,   1));
        send_event(status_event(OP_POLL, 48'd1240001, BUS_OFF,        0,   0,   1));
        send_event(status_event(OP_HARD, 48'd1500000, BUS_OFF,        255, 255, 0));
        send_event(status_event(OP_HARD, 48'd1600000, BUS_RUNNING,    255, 255, 1));
        send_event(status_event(OP_HARD, 48'd2500000, BUS_STOPPED,    15,  255, 1));
        send_event(status_event(OP_HARD, 48'd2500000, BUS_STOPPED,    16,  95,  1));
        send_event(status_event(OP_HARD, 48'd2500000, BUS_RECOVERING, 16,  96,  0));
        send_event(status_event(OP_POLL, 48'd2600000, BUS_STOPPED,    0,   0,   0));
        send_event(status_event(OP_POLL, 48'd2700000, BUS_STOPPED,    0,   0,   1));
        send_event(status_event(OP_HARD, 48'd100,     BUS_OFF,        255, 255, 1));
        send_event(status_event(OP_POLL, 48'd50,      BUS_OFF,        0,   0,   1));
        send_event(status_event(OP_POLL, 48'd2800000, BUS_RUNNING,    128, 128, 1));
        send_event(status_event(OP_POLL, 48'd2900000, BUS_OFF,        0,   0,   1));
        await_drain();
        clock_us = 48'd3000000;

        // Random phases. Idle pattern rotates: none, sender 64%, receiver
        // 64%, both 10%. Halfway through each phase the sender stops and
        // waits for every result before resuming.
        for (s = 0; s < PHASES; s++) begin
            if (s > 0) begin
                setting = phase_setting(s);
                load_config(setting);
                // jump forward so the upper time bits get exercised
                clock_us = clock_us + (time_t'($urandom) << (2 * s + 1));
            end
            case (s % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 64; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 64; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (i = 0; i < PHASE_LEN; i++) begin
                if (i == PHASE_LEN / 2)
                    await_drain();
                send_event(random_event());
            end
            await_drain();
        end

        // Top of the time range last: sums saturate and every stamp ends up
        // pinned high, which would starve any later phase.
        setting = phase_setting(PHASES);
        load_config(setting);
        idle_pct = 10;
        stall_pct = 10;
        clock_us = TIME_LIMIT - time_t'($urandom_range(0, 3000000));
        for (i = 0; i < TOP_EVENTS; i++)
            send_event(random_event());
        send_event(status_event(OP_POLL, TIME_LIMIT, BUS_STOPPED, 255, 0, 1));
        send_event(status_event(OP_HARD, TIME_LIMIT, BUS_RUNNING, 255, 255, 1));
        await_drain();

        // let any stray result transfers show up before the final check
        repeat (8) @(posedge clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
hdl/cbrs_pkg.sv
hdl/cbrs_step.sv
hdl/can_busoff_recovery_supervisor.sv
sim/cbrs_check_pkg.sv
sim/can_busoff_recovery_supervisor_test.sv
